// ===== hw/rtl/crt_pkg.sv =====
// ----------------------------------------------------------------------------
// Colour ramp lookup package
// Request and status codes and the request/result payload types.
// ----------------------------------------------------------------------------
package crt_pkg;

	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_GET    = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_CONFLICT = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] pos;
		logic [7:0]         in_red;
		logic [7:0]         in_green;
		logic [7:0]         in_blue;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [4:0] count;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE, S_RD0, S_RDL, S_BS, S_SHIFT, S_WR, S_RDK, S_RDK1, S_LOAD, S_DIV, S_OUT
	} state_t;

endpackage

// ===== hw/rtl/crt_if.sv =====
// ----------------------------------------------------------------------------
// Colour ramp stream interface
// Valid/ready channel carrying a payload of a given type.
// ----------------------------------------------------------------------------
interface crt_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/crt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module crt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hw/rtl/crt_front.sv =====
// ----------------------------------------------------------------------------
// Colour ramp front end
// Accepts requests and queues them, two deep, for the engine.
// ----------------------------------------------------------------------------
module crt_front (
	input  logic clk,
	input  logic arst_n,
	crt_if.sink   req,
	crt_if.source q
);
	crt_pkg::req_t buf_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    fill_q;

	assign req.ready = (fill_q != 2'd2);
	assign q.valid   = (fill_q != 2'd0);
	assign q.data    = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (req.valid && req.ready)
			buf_q[wp_q] <= req.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (req.valid && req.ready)
				wp_q <= ~wp_q;
			if (q.valid && q.ready)
				rp_q <= ~rp_q;
			fill_q <= fill_q + 2'(req.valid && req.ready) - 2'(q.valid && q.ready);
		end
	end
endmodule

// ===== hw/rtl/crt_engine.sv =====
// ----------------------------------------------------------------------------
// Colour ramp engine
// Binary search, ordered insert by shifting, and serial interpolation divide.
// ----------------------------------------------------------------------------
module crt_engine #(
	parameter int MAX_POINTS = 16
) (
	input  logic clk,
	input  logic arst_n,
	crt_if.sink   q,
	crt_if.source res
);
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	crt_pkg::state_t st_q, st_d;
	crt_pkg::req_t   r_q;
	crt_pkg::res_t   acc_q;
	crt_pkg::res_t   out_q;
	crt_pkg::res_t   fin;
	logic            out_v_q;
	logic [CW-1:0]   total_q;
	logic [CW-1:0]   lo_q, hi_q, j_q;   // lo ends as the count of points <= x
	logic            hit_q, itp_q;
	logic [AW-1:0]   raddr;
	logic            we;
	logic [AW-1:0]   waddr;
	logic [55:0]     wdata, rdata;
	logic signed [31:0] x0_q;
	logic [23:0]     c0_q;
	logic [32:0]     den_q;
	logic [32:0]     num_w;
	logic [41:0]     rem_q [3];
	logic [7:0]      quo_q [3];
	logic            neg_q [3];
	logic [8:0]      dif [3];
	logic [7:0]      mag [3];
	logic [3:0]      bit_q;
	logic [2:0]      qbit;
	logic [41:0]     dtrial;
	logic [CW:0]     mid_sum;
	logic [CW-1:0]   mid;
	logic            take, give, out_free;

	crt_ram #(.WIDTH(56), .DEPTH(MAX_POINTS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	wire signed [31:0] rpos = rdata[55:24];
	wire [23:0]        rcol = rdata[23:0];

	// Round the midpoint up so the search always narrows
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + (CW+1)'(1);
	assign mid     = mid_sum[CW:1];

	assign take     = q.valid && q.ready;
	assign give     = res.valid && res.ready;
	assign out_free = !out_v_q || res.ready;

	assign q.ready   = (st_q == crt_pkg::S_IDLE);
	assign res.valid = out_v_q;
	assign res.data  = out_q;

	assign num_w  = {r_q.pos[31], r_q.pos} - {x0_q[31], x0_q};
	assign qbit   = 3'(bit_q - 4'd1);
	assign dtrial = {9'd0, den_q} << qbit;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			dif[c] = {1'b0, rcol[8*c +: 8]} - {1'b0, c0_q[8*c +: 8]};
			mag[c] = dif[c][8] ? 8'(-dif[c]) : dif[c][7:0];
		end
	end

	always_comb begin
		fin = acc_q;
		if (itp_q) begin
			fin.out_red   = neg_q[2] ? c0_q[23:16] - quo_q[2] : c0_q[23:16] + quo_q[2];
			fin.out_green = neg_q[1] ? c0_q[15:8] - quo_q[1] : c0_q[15:8] + quo_q[1];
			fin.out_blue  = neg_q[0] ? c0_q[7:0] - quo_q[0] : c0_q[7:0] + quo_q[0];
		end
	end

	always_comb begin
		st_d  = st_q;
		raddr = '0;
		we    = 1'b0;
		waddr = AW'(j_q);
		wdata = rdata;
		unique case (st_q)
			crt_pkg::S_IDLE: begin
				if (take) begin
					if (q.data.req_type == crt_pkg::REQ_ADD && total_q == CW'(MAX_POINTS))
						st_d = crt_pkg::S_OUT;
					else if (q.data.req_type == crt_pkg::REQ_ADD ||
					         q.data.req_type == crt_pkg::REQ_GET)
						st_d = crt_pkg::S_BS;
					else
						st_d = crt_pkg::S_OUT;
				end
			end
			crt_pkg::S_BS: begin
				if (lo_q == hi_q) begin
					st_d = crt_pkg::S_RDL;
				end else begin
					raddr = AW'(mid - CW'(1));
					st_d  = crt_pkg::S_RD0;
				end
			end
			crt_pkg::S_RD0: st_d = crt_pkg::S_BS;
			crt_pkg::S_RDL: begin
				if (r_q.req_type == crt_pkg::REQ_ADD) begin
					if (hit_q)
						st_d = crt_pkg::S_OUT;
					else if (total_q == lo_q)
						st_d = crt_pkg::S_WR;
					else
						st_d = crt_pkg::S_SHIFT;
				end else if (total_q == '0 || hit_q) begin
					st_d = crt_pkg::S_OUT;
				end else begin
					st_d = crt_pkg::S_RDK;
				end
			end
			crt_pkg::S_SHIFT: begin
				raddr = AW'(j_q - CW'(1));
				st_d  = crt_pkg::S_WR;
			end
			crt_pkg::S_WR: begin
				we = 1'b1;
				if (j_q == lo_q) begin
					wdata = {r_q.pos, r_q.in_red, r_q.in_green, r_q.in_blue};
					st_d  = crt_pkg::S_OUT;
				end else if ((j_q - CW'(1)) == lo_q) begin
					st_d = crt_pkg::S_WR;
				end else begin
					st_d = crt_pkg::S_SHIFT;
				end
			end
			crt_pkg::S_RDK: begin
				// below the first point read point zero, otherwise point lo-1
				raddr = (lo_q == '0) ? '0 : AW'(lo_q - CW'(1));
				st_d  = crt_pkg::S_RDK1;
			end
			crt_pkg::S_RDK1: begin
				if (itp_q) begin
					raddr = AW'(lo_q);
					st_d  = crt_pkg::S_LOAD;
				end else begin
					st_d = crt_pkg::S_OUT;
				end
			end
			crt_pkg::S_LOAD: st_d = crt_pkg::S_DIV;
			crt_pkg::S_DIV: if (bit_q == 4'd1) st_d = crt_pkg::S_OUT;
			crt_pkg::S_OUT: if (out_free) st_d = crt_pkg::S_IDLE;
			default: st_d = crt_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= crt_pkg::S_IDLE;
		else
			st_q <= st_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			total_q <= '0;
		end else begin
			if (st_q == crt_pkg::S_OUT && out_free)
				out_v_q <= 1'b1;
			else if (give)
				out_v_q <= 1'b0;
			if (take && q.data.req_type == crt_pkg::REQ_CLEAR)
				total_q <= '0;
			else if (st_q == crt_pkg::S_RDL && r_q.req_type == crt_pkg::REQ_ADD && !hit_q)
				total_q <= total_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			crt_pkg::S_IDLE: begin
				if (take) begin
					r_q   <= q.data;
					lo_q  <= '0;
					hi_q  <= total_q;
					hit_q <= 1'b0;
					itp_q <= 1'b0;
					acc_q.status <= (q.data.req_type == crt_pkg::REQ_ADD &&
					                 total_q == CW'(MAX_POINTS)) ?
					                crt_pkg::ST_FULL : crt_pkg::ST_OK;
					acc_q.out_red   <= '0;
					acc_q.out_green <= '0;
					acc_q.out_blue  <= '0;
					acc_q.count     <= (q.data.req_type == crt_pkg::REQ_CLEAR) ?
					                   5'd0 : 5'(total_q);
				end
			end
			crt_pkg::S_RD0: begin
				// rdata holds point mid-1
				if (rpos <= r_q.pos) begin
					lo_q <= mid;
					if (rpos == r_q.pos) begin
						hit_q <= 1'b1;
						c0_q  <= rcol;
					end
				end else begin
					hi_q <= mid - CW'(1);
				end
			end
			crt_pkg::S_RDL: begin
				j_q   <= total_q;
				itp_q <= (r_q.req_type == crt_pkg::REQ_GET) && !hit_q &&
				         (lo_q != '0) && (lo_q != total_q);
				if (r_q.req_type == crt_pkg::REQ_ADD) begin
					if (hit_q)
						acc_q.status <= (c0_q == {r_q.in_red, r_q.in_green, r_q.in_blue}) ?
						                crt_pkg::ST_OK : crt_pkg::ST_CONFLICT;
					else
						acc_q.count <= 5'(total_q + CW'(1));
				end else if (hit_q) begin
					{acc_q.out_red, acc_q.out_green, acc_q.out_blue} <= c0_q;
				end
			end
			crt_pkg::S_WR: begin
				if (j_q != lo_q)
					j_q <= j_q - CW'(1);
			end
			crt_pkg::S_RDK1: begin
				x0_q <= rpos;
				c0_q <= rcol;
				if (!itp_q)
					{acc_q.out_red, acc_q.out_green, acc_q.out_blue} <= rcol;
			end
			crt_pkg::S_LOAD: begin
				// rdata holds the point above x
				den_q <= {rpos[31], rpos} - {x0_q[31], x0_q};
				for (int c = 0; c < 3; c++) begin
					neg_q[c] <= dif[c][8];
					rem_q[c] <= {34'd0, mag[c]} * {9'd0, num_w};
					quo_q[c] <= '0;
				end
				bit_q <= 4'd8;
			end
			crt_pkg::S_DIV: begin
				for (int c = 0; c < 3; c++) begin
					if (rem_q[c] >= dtrial) begin
						rem_q[c]       <= rem_q[c] - dtrial;
						quo_q[c][qbit] <= 1'b1;
					end
				end
				bit_q <= bit_q - 4'd1;
			end
			crt_pkg::S_OUT: begin
				if (out_free)
					out_q <= fin;
			end
			default: ;
		endcase
	end
endmodule

// ===== hw/rtl/color_ramp_table_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// Colour ramp table lookup unit
// Sorted control-point table with interpolated colour lookup.
// ----------------------------------------------------------------------------
// One request at a time, one result per request. A request is registered in
// the two-entry front queue, then the engine takes it when idle. Clear, full
// and unused requests go straight to the output state. Add and get run a
// binary search over the point RAM, each step a search state and a read
// state; an add then shifts each entry above the new point with a read and a
// write and then writes the point; a get between two points reads the points
// on either side and runs an eight-step restoring divide. A result register
// lets the engine start the next request while a result waits for transfer.
module color_ramp_table_lookup_unit #(
	parameter int MAX_POINTS = 16
) (
	input logic clk,
	input logic arst_n,
	crt_if.sink   req,
	crt_if.source res
);
	crt_if #(.T(crt_pkg::req_t)) q_if ();

	crt_front u_front (.clk(clk), .arst_n(arst_n), .req(req), .q(q_if));
	crt_engine #(.MAX_POINTS(MAX_POINTS)) u_engine (
		.clk(clk), .arst_n(arst_n), .q(q_if), .res(res)
	);
endmodule
